// ----- design/gpa_pkg.sv -----
// ----------------------------------------------------------------------------
// gpa_pkg: shared types for the binary polynomial ALU
// Widths, transaction payloads and the record that moves along the cell row.
// ----------------------------------------------------------------------------
package gpa_pkg;

  localparam int POLY_W = 8;
  localparam int PROD_W = 2 * POLY_W - 1;
  localparam int MOD_W  = POLY_W + 1;
  localparam int DEG_W  = $clog2(POLY_W);

  localparam logic [POLY_W-1:0] MOD_LOW_RESET = POLY_W'(9'h11B);

  typedef struct packed {
    logic [POLY_W-1:0] operand_a;
    logic [POLY_W-1:0] operand_b;
  } gpa_in_t;

  typedef struct packed {
    logic [POLY_W-1:0] poly_sum;
    logic [PROD_W-1:0] product_full;
    logic [POLY_W-1:0] product_reduced;
    logic [POLY_W-1:0] quotient;
    logic              divide_by_zero;
  } gpa_out_t;

  // Partial results of one transaction as it passes from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [POLY_W-1:0] a;
    logic [POLY_W-1:0] b;
    logic [POLY_W-1:0] sum;
    logic [PROD_W-1:0] prod;
    logic [POLY_W-1:0] red;
    logic [POLY_W-1:0] rem;
    logic [POLY_W-1:0] quo;
    logic [DEG_W-1:0]  deg;
    logic              dz;
  } gpa_stage_t;

endpackage

// ----- design/gpa_cell.sv -----
// ----------------------------------------------------------------------------
// gpa_cell: one step of multiply, reduce and long division
// Handles one coefficient of operand_a and one quotient position per cycle.
// ----------------------------------------------------------------------------
module gpa_cell
  import gpa_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [POLY_W-1:0] mod_low,
  input  gpa_stage_t        stage_in,
  output gpa_stage_t        stage_out
);

  // Horner order: cell 0 takes the top coefficient, which is also the top
  // quotient position.
  localparam int SHIFT = POLY_W - 1 - IDX;

  gpa_stage_t        stage_next;
  logic [POLY_W-1:0] pp;
  logic [DEG_W:0]    pos;
  logic              rem_bit;
  logic              hit;

  always_comb begin
    pp  = stage_in.a[SHIFT] ? stage_in.b : '0;
    pos = {1'b0, stage_in.deg} + (DEG_W+1)'(SHIFT);
    rem_bit = (pos < (DEG_W+1)'(POLY_W)) ? stage_in.rem[pos[DEG_W-1:0]] : 1'b0;
    hit = !stage_in.dz && rem_bit;

    stage_next = stage_in;
    stage_next.prod = {stage_in.prod[PROD_W-2:0], 1'b0}
                      ^ {{(PROD_W-POLY_W){1'b0}}, pp};
    stage_next.red = {stage_in.red[POLY_W-2:0], 1'b0}
                     ^ (stage_in.red[POLY_W-1] ? mod_low : '0) ^ pp;
    if (hit) begin
      stage_next.rem        = stage_in.rem ^ POLY_W'(stage_in.b << SHIFT);
      stage_next.quo[SHIFT] = 1'b1;
    end
    if (rst) begin
      stage_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    stage_out <= stage_next;
  end

endmodule

// ----- design/gf2p8_polynomial_alu.sv -----
// ----------------------------------------------------------------------------
// gf2p8_polynomial_alu: sum, carry-less product, field product and quotient
// A row of POLY_W cells, each taking one operand bit, gives all four results.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | start, busy          | operands  (gpa_in_t)
//  result   | done (one cycle)     | result    (gpa_out_t)
//  config   | cfg_valid, cfg_ready | cfg_data  (field modulus)
//
// A transaction is accepted every cycle while reset is low; its result passes
// through the POLY_W cells of the row, one register per cell.
// Reset clears the row's valid bits and loads the modulus 0x11B; busy is
// high and cfg_ready is low while reset is high.
// The result side cannot stall, so the row never holds back.
// ----------------------------------------------------------------------------
module gf2p8_polynomial_alu
  import gpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  gpa_in_t          operands,
  output logic             done,
  output gpa_out_t         result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MOD_W-1:0] cfg_data
);

  logic [POLY_W-1:0] mod_low;
  gpa_stage_t        row [POLY_W+1];
  logic [DEG_W-1:0]  deg_b;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // The x^POLY_W coefficient is implied, so only the low bits are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_low <= MOD_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mod_low <= cfg_data[POLY_W-1:0];
    end
  end

  always_comb begin
    deg_b = '0;
    for (int i = 0; i < POLY_W; i++) begin
      if (operands.operand_b[i]) begin
        deg_b = DEG_W'(i);
      end
    end
  end

  always_comb begin
    row[0].valid = start && !busy;
    row[0].a     = operands.operand_a;
    row[0].b     = operands.operand_b;
    row[0].sum   = operands.operand_a ^ operands.operand_b;
    row[0].prod  = '0;
    row[0].red   = '0;
    row[0].rem   = operands.operand_a;
    row[0].quo   = '0;
    row[0].deg   = deg_b;
    row[0].dz    = (operands.operand_b == '0);
  end

  for (genvar k = 0; k < POLY_W; k++) begin : g_cell
    gpa_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .mod_low  (mod_low),
      .stage_in (row[k]),
      .stage_out(row[k+1])
    );
  end

  assign done                   = row[POLY_W].valid;
  assign result.poly_sum        = row[POLY_W].sum;
  assign result.product_full    = row[POLY_W].prod;
  assign result.product_reduced = row[POLY_W].red;
  assign result.quotient        = row[POLY_W].dz ? '0 : row[POLY_W].quo;
  assign result.divide_by_zero  = row[POLY_W].dz;

endmodule

// ----- design/gpa_checker.sv -----
// ----------------------------------------------------------------------------
// gpa_checker: port-level checks for the polynomial ALU
// Latency and result consistency as seen on the top level's ports.
// ----------------------------------------------------------------------------
module gpa_checker
  import gpa_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input gpa_in_t          operands,
  input logic             done,
  input gpa_out_t         result
);

  // Every accepted transaction comes out once it has passed the whole row.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##POLY_W done)
    else $error("accepted transaction did not complete on time");

  // No result appears without an accepted transaction that has passed the whole row.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, POLY_W))
    else $error("result strobe without a matching transaction");

  a_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> result.poly_sum ==
             $past(operands.operand_a ^ operands.operand_b, POLY_W))
    else $error("sum does not match the operands");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.divide_by_zero == ($past(operands.operand_b, POLY_W) == '0))
             && (!result.divide_by_zero || result.quotient == '0))
    else $error("zero-divisor flag or quotient is wrong");

endmodule

bind gf2p8_polynomial_alu gpa_checker u_gpa_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gf2p8_polynomial_alu
// Drives operand pairs through the command port and checks every result
// against a predictor of the sum, the carry-less product, the field product
// and the polynomial quotient. The bench reprograms the modulus between
// phases, including the corner values, and inserts random gaps between items.
// ----------------------------------------------------------------------------
module tb;
  import gpa_pkg::*;

  localparam int LATENCY     = POLY_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 145;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  gpa_in_t          operands  = '0;
  logic             cfg_valid = 1'b0;
  logic [MOD_W-1:0] cfg_data  = '0;
  logic             busy;
  logic             done;
  gpa_out_t         result;
  logic             cfg_ready;

  gpa_out_t         pending_results[$];
  logic [MOD_W-1:0] field_mod = MOD_W'(9'h11B);
  int               error_count   = 0;
  int               items_sent    = 0;
  int               results_seen  = 0;
  int               mod_writes    = 0;
  int               zero_divisors = 0;
  int               cycle_count   = 0;

  gf2p8_polynomial_alu dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operands  (operands),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [PROD_W-1:0] clmul_poly(logic [POLY_W-1:0] x,
                                                   logic [POLY_W-1:0] y);
    logic [PROD_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < POLY_W; i++) begin
      if (x[i]) acc ^= PROD_W'(y) << i;
    end
    return acc;
  endfunction

  // The x^8 coefficient of the modulus is implied, so only the low bits matter.
  function automatic logic [POLY_W-1:0] reduce_poly(logic [PROD_W-1:0] p,
                                                    logic [MOD_W-1:0] m);
    logic [PROD_W-1:0] low;
    low = PROD_W'(m[POLY_W-1:0]);
    for (int i = PROD_W - 1; i >= POLY_W; i--) begin
      if (p[i]) begin
        p[i] = 1'b0;
        p ^= low << (i - POLY_W);
      end
    end
    return p[POLY_W-1:0];
  endfunction

  function automatic logic [POLY_W-1:0] divide_poly(logic [POLY_W-1:0] a,
                                                    logic [POLY_W-1:0] b);
    logic [POLY_W-1:0] rem;
    logic [POLY_W-1:0] q;
    int db;
    rem = a;
    q   = '0;
    db  = -1;
    for (int i = 0; i < POLY_W; i++) begin
      if (b[i]) db = i;
    end
    if (db < 0) return '0;
    for (int s = POLY_W - 1 - db; s >= 0; s--) begin
      if (rem[db+s]) begin
        rem ^= b << s;
        q[s] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic gpa_out_t alu_predict(gpa_in_t op, logic [MOD_W-1:0] m);
    gpa_out_t r;
    r.poly_sum        = op.operand_a ^ op.operand_b;
    r.product_full    = clmul_poly(op.operand_a, op.operand_b);
    r.product_reduced = reduce_poly(r.product_full, m);
    r.divide_by_zero  = (op.operand_b == '0);
    r.quotient        = r.divide_by_zero ? '0 : divide_poly(op.operand_a, op.operand_b);
    return r;
  endfunction

  // Presents one operand pair and returns at the edge that accepts it, with
  // start still high so that a following item can go out back to back.
  task automatic send_operands(logic [POLY_W-1:0] a, logic [POLY_W-1:0] b);
    gpa_in_t op;
    op.operand_a = a;
    op.operand_b = b;
    start    <= 1'b1;
    operands <= op;
    do @(posedge clk); while (busy);
    pending_results.push_back(alu_predict(op, field_mod));
    items_sent++;
    if (b == '0) zero_divisors++;
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The modulus changes only with the row empty.
  task automatic write_modulus(logic [MOD_W-1:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    field_mod = value;
    mod_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [PROD_W-1:0] exp_v,
                             logic [PROD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    gpa_out_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("poly_sum", PROD_W'(want.poly_sum), PROD_W'(result.poly_sum));
        check_field("product_full", want.product_full, result.product_full);
        check_field("product_reduced", PROD_W'(want.product_reduced),
                    PROD_W'(result.product_reduced));
        check_field("quotient", PROD_W'(want.quotient), PROD_W'(result.quotient));
        check_field("divide_by_zero", PROD_W'(want.divide_by_zero),
                    PROD_W'(result.divide_by_zero));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Reset modulus: operand extremes, zero divisor, unit divisor and a
  // dividend of lower degree than the divisor.
  task automatic test_reset_modulus();
    send_operands(8'h00, 8'h00);
    send_operands(8'hFF, 8'hFF);
    send_operands(8'hFF, 8'h00);
    send_operands(8'h00, 8'hFF);
    send_operands(8'h01, 8'h01);
    hold_off(3);
    send_operands(8'h57, 8'h83);
    send_operands(8'hFF, 8'h01);
    send_operands(8'h01, 8'h80);
    send_operands(8'h7F, 8'h80);
    hold_off(1);
    send_operands(8'h80, 8'h80);
    send_operands(8'hAA, 8'h55);
    send_operands(8'h55, 8'h03);
  endtask

  // Modulus corners: all ones, top bit clear, and low bits all zero.
  task automatic test_modulus_corners();
    write_modulus(9'h1FF);
    send_operands(8'hFF, 8'hFF);
    send_operands(8'h80, 8'h02);
    send_operands(8'hC3, 8'h00);
    send_operands(8'h9D, 8'h07);
    write_modulus(9'h0FF);
    send_operands(8'hFF, 8'hFF);
    send_operands(8'h80, 8'h02);
    hold_off(2);
    send_operands(8'hE1, 8'h11);
    send_operands(8'h3C, 8'h80);
    write_modulus(9'h100);
    send_operands(8'hFF, 8'hFF);
    send_operands(8'h80, 8'h80);
    send_operands(8'h12, 8'h34);
  endtask

  task automatic test_random_traffic();
    logic [MOD_W-1:0] mod_list[7];
    logic [POLY_W-1:0] a;
    logic [POLY_W-1:0] b;
    bit quiet;
    int r;
    mod_list[0] = 9'h11B;
    mod_list[1] = 9'h000;
    mod_list[2] = 9'h1FF;
    mod_list[3] = MOD_W'($urandom);
    mod_list[4] = MOD_W'($urandom_range(256, 511));
    mod_list[5] = MOD_W'($urandom);
    mod_list[6] = MOD_W'($urandom_range(256, 511));
    foreach (mod_list[p]) begin
      write_modulus(mod_list[p]);
      quiet = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 19);
        case (r)
          0:       b = '0;
          1:       b = 8'h01;
          2:       b = 8'h80 | POLY_W'($urandom);
          3:       b = POLY_W'($urandom_range(1, 15));
          default: b = POLY_W'($urandom);
        endcase
        r = $urandom_range(0, 19);
        case (r)
          0:       a = '0;
          1:       a = 8'hFF;
          default: a = POLY_W'($urandom);
        endcase
        send_operands(a, b);
        // Long runs without gaps alternate with runs of random spacing.
        if (!quiet) hold_off(pick_gap());
        if ($urandom_range(0, 49) == 0) quiet = !quiet;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_modulus();
    test_modulus_corners();
    test_random_traffic();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("tb: %0d operand pairs sent, %0d results checked, %0d zero divisors",
             items_sent, results_seen, zero_divisors);
    $display("tb: %0d modulus writes, corner and random field polynomials",
             mod_writes);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/gpa_pkg.sv
design/gpa_cell.sv
design/gf2p8_polynomial_alu.sv
design/gpa_checker.sv
verif/tb.sv
